[hw/rtl/tagged_length_field_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Tagged length-field encoder assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TAGGED_LENGTH_FIELD_ENCODER_MACROS_SVH
`define TAGGED_LENGTH_FIELD_ENCODER_MACROS_SVH

// Same-cycle implication
`define TLFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define TLFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tlfe_pkg.sv]
// ----------------------------------------------------------------------------
// Tagged length-field encoder package
// Status codes, field number ranges and the result bundle type.
// ----------------------------------------------------------------------------
package tlfe_pkg;

	// Status codes reported in a result
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FIELD_RSVD  = 3'd1,
		ST_FIXED_LEN   = 3'd2,
		ST_TOO_LONG    = 3'd3,
		ST_TYPE_LOCKED = 3'd4,
		ST_STRAY       = 3'd5
	} status_t;

	// Input kind flag
	localparam logic KIND_HEADER = 1'b0;

	// Field number landmarks
	localparam logic [7:0] FIELD_RSVD      = 8'd251;
	localparam logic [7:0] FIELD_LEN3      = 8'd252;
	localparam logic [7:0] FIELD_FIX_A     = 8'd253;
	localparam logic [7:0] FIELD_LEN1_HI   = 8'd254;
	localparam logic [7:0] FIELD_FIX_B     = 8'd255;
	localparam logic [7:0] FIELD_FIX_LO    = 8'd4;
	localparam logic [7:0] FIELD_FIX_HI    = 8'd15;
	localparam logic [7:0] FIELD_LEN1_END  = 8'd159;
	localparam logic [7:0] FIELD_LEN2_LO   = 8'd160;
	localparam logic [7:0] FIELD_LEN2_HI   = 8'd250;

	// Object types at or above this are encrypted kinds, not writable
	localparam logic [2:0] OBJ_TYPE_ENC_MIN = 3'd5;

	// Up to four results per request: tag plus up to three length bytes
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            byte_valid;
		logic            eof;
		status_t         status;
	} bundle_t;

	// One result as it leaves the block
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       eof;
		logic       last;
		status_t    status;
	} result_t;

	// Number of length bytes for a field number (251 reads as 0, caught apart)
	function automatic logic [1:0] prefix_len(input logic [7:0] f);
		logic [1:0] pl;
		if (f == 8'd0 || (f >= FIELD_FIX_LO && f <= FIELD_FIX_HI) ||
				f == FIELD_FIX_A || f == FIELD_FIX_B || f == FIELD_RSVD)
			pl = 2'd0;
		else if (f >= FIELD_LEN2_LO && f <= FIELD_LEN2_HI)
			pl = 2'd2;
		else if (f == FIELD_LEN3)
			pl = 2'd3;
		else
			pl = 2'd1;
		return pl;
	endfunction

endpackage

[hw/rtl/tlfe_front.sv]
// ----------------------------------------------------------------------------
// Tagged length-field encoder front end
// Classifies each request, checks lengths, keeps the field counter state
// and builds the result bundle for the emitter.
// ----------------------------------------------------------------------------
`include "tagged_length_field_encoder_macros.svh"

module tlfe_front #(
	parameter int FIXED_PAYLOAD_BYTES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [2:0]        cfg_wr_data,
	input  logic              accept,
	input  logic              kind,
	input  logic [7:0]        field_number,
	input  logic [23:0]       payload_length,
	input  logic [7:0]        data_byte,
	output logic              push,
	output tlfe_pkg::bundle_t bundle
);
	import tlfe_pkg::*;

	logic [2:0]  object_type_q;
	logic [23:0] rem_q, rem_d;
	logic        open_q, open_d;
	logic        drop_q, drop_d;

	logic [1:0]  pl;
	logic        len_nz, rem_nz, enc_type, too_long;
	status_t     hdr_status;
	logic [23:0] rem_dec;

	// Header classification
	assign pl       = prefix_len(field_number);
	assign len_nz   = (payload_length != 24'd0);
	assign rem_nz   = (rem_q != 24'd0);
	assign rem_dec  = rem_q - {23'd0, rem_nz};
	assign enc_type = (object_type_q >= OBJ_TYPE_ENC_MIN);

	always_comb begin
		if (enc_type)
			too_long = len_nz;
		else if (pl == 2'd1)
			too_long = |payload_length[23:8];
		else if (pl == 2'd2)
			too_long = |payload_length[23:16];
		else
			too_long = 1'b0;
	end

	// Error checks in priority order
	always_comb begin
		priority if (field_number == FIELD_RSVD)
			hdr_status = ST_FIELD_RSVD;
		else if (pl == 2'd0 && payload_length != 24'(FIXED_PAYLOAD_BYTES))
			hdr_status = ST_FIXED_LEN;
		else if (pl != 2'd0 && too_long)
			hdr_status = ST_TOO_LONG;
		else if (enc_type)
			hdr_status = ST_TYPE_LOCKED;
		else
			hdr_status = ST_OK;
	end

	// Next state and result bundle
	always_comb begin
		rem_d  = rem_q;
		open_d = open_q;
		drop_d = drop_q;
		push   = 1'b0;
		bundle = '{bytes: '0, last_idx: 2'd0, byte_valid: 1'b0, eof: 1'b0,
			status: ST_OK};
		if (kind == KIND_HEADER) begin
			push  = 1'b1;
			rem_d = payload_length;
			if (hdr_status != ST_OK) begin
				bundle.status = hdr_status;
				open_d        = 1'b0;
				drop_d        = len_nz;
			end else begin
				bundle.byte_valid = 1'b1;
				bundle.last_idx   = pl;
				bundle.eof        = !len_nz;
				bundle.bytes[0]   = field_number;
				open_d            = len_nz;
				drop_d            = 1'b0;
				unique case (pl)
					2'd0: ;
					2'd1: bundle.bytes[1] = payload_length[7:0];
					2'd2: begin
						bundle.bytes[1] = payload_length[15:8];
						bundle.bytes[2] = payload_length[7:0];
					end
					2'd3: begin
						bundle.bytes[1] = payload_length[23:16];
						bundle.bytes[2] = payload_length[15:8];
						bundle.bytes[3] = payload_length[7:0];
					end
					default: ;
				endcase
			end
		end else if (drop_q) begin
			// discard payload of a rejected field
			rem_d  = rem_dec;
			drop_d = (rem_dec != 24'd0);
		end else if (open_q && rem_nz) begin
			push              = 1'b1;
			rem_d             = rem_dec;
			open_d            = (rem_dec != 24'd0);
			bundle.bytes[0]   = data_byte;
			bundle.byte_valid = 1'b1;
			bundle.eof        = (rem_dec == 24'd0);
		end else begin
			// payload byte with no field open
			push          = 1'b1;
			open_d        = 1'b0;
			bundle.status = ST_STRAY;
		end
	end

	// Field state, updated per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			open_q <= 1'b0;
			drop_q <= 1'b0;
		end else if (accept) begin
			rem_q  <= rem_d;
			open_q <= open_d;
			drop_q <= drop_d;
		end
	end

	// Object type register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			object_type_q <= '0;
		else if (cfg_wr_en)
			object_type_q <= cfg_wr_data;
	end

	`TLFE_ASSERT_NOW(a_open_drop_excl, open_q, !drop_q, "field open while dropping")
	`TLFE_ASSERT_NOW(a_open_has_bytes, open_q, rem_nz, "open field with zero count")
	`TLFE_ASSERT_NOW(a_drop_has_bytes, drop_q, rem_nz, "dropping with zero count")

endmodule

[hw/rtl/tlfe_emit.sv]
// ----------------------------------------------------------------------------
// Tagged length-field encoder emitter
// Holds one result bundle and sends its results one per cycle when the output
// is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`include "tagged_length_field_encoder_macros.svh"

module tlfe_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tlfe_pkg::bundle_t bundle,
	output logic              take_ok,
	output logic              out_valid,
	input  logic              out_ready,
	output tlfe_pkg::result_t result
);
	import tlfe_pkg::*;

	logic       valid_s1;
	bundle_t    bundle_s1;
	logic [1:0] idx_q;
	logic       out_valid_q;
	result_t    result_q;
	logic       out_free, pop, done, at_last;

	assign out_free = !out_valid_q || out_ready;
	assign at_last  = (idx_q == bundle_s1.last_idx);
	assign pop      = valid_s1 && out_free;
	assign done     = pop && at_last;
	assign take_ok  = !valid_s1 || done;

	// Bundle stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (push)
				valid_s1 <= 1'b1;
			else if (done)
				valid_s1 <= 1'b0;
			if (done)
				idx_q <= '0;
			else if (pop)
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			bundle_s1 <= bundle;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.out_byte   <= bundle_s1.bytes[idx_q];
			result_q.byte_valid <= bundle_s1.byte_valid;
			result_q.eof        <= bundle_s1.eof && at_last;
			result_q.last       <= at_last;
			result_q.status     <= bundle_s1.status;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	`TLFE_ASSERT_NOW(a_idx_bound, valid_s1, idx_q <= bundle_s1.last_idx, "index past bundle")
	`TLFE_ASSERT_NOW(a_idx_idle, !valid_s1, idx_q == 2'd0, "index moved while empty")
	`TLFE_ASSERT_NEXT(a_idx_step, pop && !at_last,
		valid_s1 && idx_q == 2'($past(idx_q) + 2'd1), "bundle lost mid-sequence")

endmodule

[hw/rtl/tagged_length_field_encoder.sv]
// Results pass through the bundle stage and then the output register.
// Payload bytes: one request per clock while the output is ready; a header
// holds the input until its 1 to 4 results enter the one-byte output register.
// Dropped payload bytes produce no result and pass one per clock when idle.
// Reset (arst_n low, async): no field open, counter zero, object type 0,
// bundle and output stages empty.
// ----------------------------------------------------------------------------
// Tagged length-field encoder top level
// Emits tag and big-endian length bytes for each valid field header, then
// passes the field's payload bytes while counting them down.
// ----------------------------------------------------------------------------
module tagged_length_field_encoder #(
	parameter int FIXED_PAYLOAD_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,   // object_type
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // field_number, payload_length, data_byte
	input  logic        s_axis_tuser,  // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // out_byte, status, 5 zero bits
	output logic [1:0]  m_axis_tuser,  // byte_valid, end_of_field
	output logic        m_axis_tlast   // last result of the request
);
	import tlfe_pkg::*;

	logic    accept, push, take_ok;
	bundle_t bundle;
	result_t result;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = take_ok;

	// Classification and field state
	tlfe_front #(
		.FIXED_PAYLOAD_BYTES(FIXED_PAYLOAD_BYTES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.accept        (accept),
		.kind          (s_axis_tuser),
		.field_number  (s_axis_tdata[7:0]),
		.payload_length(s_axis_tdata[31:8]),
		.data_byte     (s_axis_tdata[39:32]),
		.push          (push),
		.bundle        (bundle)
	);

	// Result sequencing and output register
	tlfe_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push && accept),
		.bundle   (bundle),
		.take_ok  (take_ok),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.result   (result)
	);

	// Output packing
	assign m_axis_tdata = {5'd0, result.status, result.out_byte};
	assign m_axis_tuser = {result.eof, result.byte_valid};
	assign m_axis_tlast = result.last;

endmodule
